[sv/mhpq_pkg.sv]
package mhpq_pkg;

    localparam int CAPACITY = 64;
    localparam int ADDR_W = $clog2(CAPACITY);
    localparam logic signed [31:0] INT_MAX = 32'sh7FFF_FFFF;

    typedef enum logic [1:0] {
        REQ_INSERT  = 2'd0,
        REQ_EXTRACT = 2'd1,
        REQ_REMOVE  = 2'd2,
        REQ_CHANGE  = 2'd3
    } req_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2,
        ST_RANGE = 2'd3
    } status_t;

endpackage

[sv/max_heap_priority_queue_core.sv]
// Binary max-heap of 64 signed 32-bit priorities held in one synchronous RAM.
// An error is signalled on the result strobe in the cycle after acceptance; otherwise
// the result follows a sift-up for insert, a sift-down for extract, one of the two
// for change, and a sift-up to the root followed by a sift-down for remove.
// Throughput: one transaction at a time; busy is high until the state machine is
// idle again, and a new transaction can be accepted while the result is shown.
// Reset clears the entry count and control state; the RAM needs no clearing.
// The result is shown for one cycle on done; the receiver cannot stall.
module max_heap_priority_queue_core
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic [1:0]           req_type,
    input  logic [6:0]           position,
    input  logic signed [31:0]   priority_req,
    output logic                 done,
    output logic signed [31:0]   result_value,
    output logic [1:0]           status,
    output logic [6:0]           entry_count
);
    import mhpq_pkg::*;

    typedef enum logic [9:0] {
        S_IDLE   = 10'b00_0000_0001,
        S_UP_RD  = 10'b00_0000_0010,
        S_UP_CMP = 10'b00_0000_0100,
        S_TK_RD1 = 10'b00_0000_1000,
        S_TK_RD2 = 10'b00_0001_0000,
        S_TK_LST = 10'b00_0010_0000,
        S_DN_RDL = 10'b00_0100_0000,
        S_DN_RDR = 10'b00_1000_0000,
        S_DN_CMP = 10'b01_0000_0000,
        S_CH_CMP = 10'b10_0000_0000
    } state_t;

    logic signed [31:0] heap_mem [0:CAPACITY-1];
    logic signed [31:0] rdata_reg;

    state_t             state_reg, state_next;
    logic [6:0]         count_reg, count_next;
    logic [6:0]         pos_reg, pos_next;
    logic signed [31:0] val_reg, val_next;
    logic signed [31:0] top_reg, top_next;
    logic signed [31:0] left_reg, left_next;
    logic               extract_reg, extract_next;
    logic               remove_reg, remove_next;
    logic               done_reg, done_next;
    logic signed [31:0] result_reg, result_next;
    logic [1:0]         status_reg, status_next;
    logic [6:0]         ecount_reg, ecount_next;

    logic               rd_en, wr_en;
    logic [ADDR_W-1:0]  rd_addr, wr_addr;
    logic signed [31:0] wdata;
    logic               fin;
    logic [7:0]         lpos, rpos;
    logic               r_ok;
    logic [6:0]         best_pos;
    logic signed [31:0] best_val;

    assign lpos = {pos_reg, 1'b0};
    assign rpos = lpos + 8'd1;
    assign r_ok = rpos <= {1'b0, count_reg};

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rdata_reg <= heap_mem[rd_addr];
        end
        if (wr_en)
        begin
            heap_mem[wr_addr] <= wdata;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        count_next   = count_reg;
        pos_next     = pos_reg;
        val_next     = val_reg;
        top_next     = top_reg;
        left_next    = left_reg;
        extract_next = extract_reg;
        remove_next  = remove_reg;
        done_next    = 1'b0;
        result_next  = result_reg;
        status_next  = status_reg;
        ecount_next  = ecount_reg;
        rd_en        = 1'b0;
        rd_addr      = '0;
        wr_en        = 1'b0;
        wr_addr      = '0;
        wdata        = val_reg;
        fin          = 1'b0;
        best_pos     = pos_reg;
        best_val     = val_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    extract_next = 1'b0;
                    remove_next  = 1'b0;
                    unique case (req_t'(req_type))
                        REQ_INSERT:
                        begin
                            if (count_reg >= 7'(CAPACITY))
                            begin
                                done_next   = 1'b1;
                                result_next = '0;
                                status_next = ST_FULL;
                                ecount_next = count_reg;
                            end
                            else
                            begin
                                count_next = count_reg + 7'd1;
                                pos_next   = count_reg + 7'd1;
                                val_next   = priority_req;
                                state_next = S_UP_RD;
                            end
                        end
                        REQ_EXTRACT:
                        begin
                            if (count_reg == 7'd0)
                            begin
                                done_next   = 1'b1;
                                result_next = '0;
                                status_next = ST_EMPTY;
                                ecount_next = count_reg;
                            end
                            else
                            begin
                                extract_next = 1'b1;
                                state_next   = S_TK_RD1;
                            end
                        end
                        REQ_REMOVE:
                        begin
                            if (position == 7'd0 || position > count_reg)
                            begin
                                done_next   = 1'b1;
                                result_next = '0;
                                status_next = ST_RANGE;
                                ecount_next = count_reg;
                            end
                            else
                            begin
                                remove_next = 1'b1;
                                pos_next    = position;
                                val_next    = INT_MAX;
                                state_next  = S_UP_RD;
                            end
                        end
                        REQ_CHANGE:
                        begin
                            if (position == 7'd0 || position > count_reg)
                            begin
                                done_next   = 1'b1;
                                result_next = '0;
                                status_next = ST_RANGE;
                                ecount_next = count_reg;
                            end
                            else
                            begin
                                pos_next   = position;
                                val_next   = priority_req;
                                rd_en      = 1'b1;
                                rd_addr    = ADDR_W'(position - 7'd1);
                                state_next = S_CH_CMP;
                            end
                        end
                    endcase
                end
            end
            S_CH_CMP:
            begin
                state_next = (val_reg > rdata_reg) ? S_UP_RD : S_DN_RDL;
            end
            S_UP_RD:
            begin
                if (pos_reg == 7'd1)
                begin
                    wr_en   = 1'b1;
                    wr_addr = '0;
                    if (remove_reg)
                    begin
                        state_next = S_TK_RD1;
                    end
                    else
                    begin
                        fin = 1'b1;
                    end
                end
                else
                begin
                    rd_en      = 1'b1;
                    rd_addr    = ADDR_W'((pos_reg >> 1) - 7'd1);
                    state_next = S_UP_CMP;
                end
            end
            S_UP_CMP:
            begin
                wr_en   = 1'b1;
                wr_addr = ADDR_W'(pos_reg - 7'd1);
                if (rdata_reg < val_reg)
                begin
                    wdata      = rdata_reg;
                    pos_next   = pos_reg >> 1;
                    state_next = S_UP_RD;
                end
                else if (remove_reg)
                begin
                    state_next = S_TK_RD1;
                end
                else
                begin
                    fin = 1'b1;
                end
            end
            S_TK_RD1:
            begin
                rd_en      = 1'b1;
                rd_addr    = '0;
                state_next = S_TK_RD2;
            end
            S_TK_RD2:
            begin
                top_next   = rdata_reg;
                rd_en      = 1'b1;
                rd_addr    = ADDR_W'(count_reg - 7'd1);
                state_next = S_TK_LST;
            end
            S_TK_LST:
            begin
                val_next   = rdata_reg;
                count_next = count_reg - 7'd1;
                pos_next   = 7'd1;
                state_next = S_DN_RDL;
            end
            S_DN_RDL:
            begin
                if (lpos > {1'b0, count_reg})
                begin
                    wr_en   = 1'b1;
                    wr_addr = ADDR_W'(pos_reg - 7'd1);
                    fin     = 1'b1;
                end
                else
                begin
                    rd_en      = 1'b1;
                    rd_addr    = ADDR_W'(lpos - 8'd1);
                    state_next = S_DN_RDR;
                end
            end
            S_DN_RDR:
            begin
                left_next = rdata_reg;
                if (r_ok)
                begin
                    rd_en   = 1'b1;
                    rd_addr = ADDR_W'(rpos - 8'd1);
                end
                state_next = S_DN_CMP;
            end
            S_DN_CMP:
            begin
                if (left_reg > best_val)
                begin
                    best_pos = lpos[6:0];
                    best_val = left_reg;
                end
                if (r_ok && rdata_reg > best_val)
                begin
                    best_pos = rpos[6:0];
                    best_val = rdata_reg;
                end
                wr_en   = 1'b1;
                wr_addr = ADDR_W'(pos_reg - 7'd1);
                if (best_pos == pos_reg)
                begin
                    fin = 1'b1;
                end
                else
                begin
                    wdata      = best_val;
                    pos_next   = best_pos;
                    state_next = S_DN_RDL;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (fin)
        begin
            state_next  = S_IDLE;
            done_next   = 1'b1;
            result_next = extract_reg ? top_reg : 32'sd0;
            status_next = ST_OK;
            ecount_next = count_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            pos_reg     <= '0;
            val_reg     <= '0;
            top_reg     <= '0;
            left_reg    <= '0;
            extract_reg <= 1'b0;
            remove_reg  <= 1'b0;
            done_reg    <= 1'b0;
            result_reg  <= '0;
            status_reg  <= '0;
            ecount_reg  <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            pos_reg     <= pos_next;
            val_reg     <= val_next;
            top_reg     <= top_next;
            left_reg    <= left_next;
            extract_reg <= extract_next;
            remove_reg  <= remove_next;
            done_reg    <= done_next;
            result_reg  <= result_next;
            status_reg  <= status_next;
            ecount_reg  <= ecount_next;
        end
    end

    assign busy         = state_reg != S_IDLE;
    assign done         = done_reg;
    assign result_value = result_reg;
    assign status       = status_reg;
    assign entry_count  = ecount_reg;

endmodule
